// File: design/ctpb_pkg.sv
// ----------------------------------------------------------------------------
// ctpb_pkg - shared types and constants of the CUC time packet builder
// Widths, register indexes, packet byte positions, the controller to
// datapath command and status types, and the RMAP CRC-8 byte update.
// ----------------------------------------------------------------------------
package ctpb_pkg;

  localparam int BYTE_W       = 8;
  localparam int ET_W         = 56;
  localparam int ET_MAX_BYTES = ET_W / BYTE_W;
  localparam int ET_BYTES_DEF = 7;
  localparam int HDR_BYTES    = 4;
  localparam int POS_W        = 4;
  localparam int CFG_IDX_W    = 2;
  localparam int TCID_W       = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROTO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TCID  = 2'd2;

  // register reset values
  localparam logic [BYTE_W-1:0] RST_DEST  = 8'hFE;
  localparam logic [BYTE_W-1:0] RST_PROTO = 8'hFE;
  localparam logic [TCID_W-1:0] RST_TCID  = 3'd1;

  // header byte positions
  localparam logic [POS_W-1:0] POS_DEST   = 4'd0;
  localparam logic [POS_W-1:0] POS_PROTO  = 4'd1;
  localparam logic [POS_W-1:0] POS_PFIELD = 4'd2;
  localparam logic [POS_W-1:0] POS_PEXT   = 4'd3;

  // reflected form of x^8+x^2+x+1
  localparam logic [BYTE_W-1:0] CRC_POLY_REFL = 8'hE0;

  // controller -> datapath
  typedef struct packed {
    logic             load;  // capture a new request
    logic             emit;  // load the output register with byte at pos
    logic [POS_W-1:0] pos;   // byte position within the packet
    logic             last;  // pos is the CRC byte
  } ctpb_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;          // output register can take a byte this cycle
  } ctpb_stat_t;

  // one table entry of the RMAP CRC-8 (entry v), eight narrow shift steps
  function automatic logic [BYTE_W-1:0] crc8_entry(input logic [BYTE_W-1:0] v);
    logic [BYTE_W-1:0] r;
    r = v;
    for (int b = 0; b < BYTE_W; b++) begin
      if (r[0]) begin
        r = (r >> 1) ^ CRC_POLY_REFL;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

endpackage

// File: design/cuc_time_packet_builder_unit.sv
// ----------------------------------------------------------------------------
// cuc_time_packet_builder_unit - CUC time packet builder over SpaceWire
// Builds a 12-byte time packet per request (address, protocol id, P-field,
// extended P-field, time bytes, RMAP CRC-8) and sends it one byte a beat.
//
//   channel  dir  signals                         beat
//   s_*      in   tvalid tready tdata tuser       one request
//   m_*      out  tvalid tready tdata tlast       one packet byte
//   cfg_*    in   valid ready index data          one register write
//
// A request is taken first, then ET_BYTES + 5 bytes enter the output
// register one per cycle while m_tready does not stall them, set by the
// byte sequencer in ctpb_ctrl.
// The next request is taken as soon as the CRC byte is in the output
// register. Stalls on m_tready hold the sequencer; cfg_ready is always high.
// Reset restores register defaults and empties the output register.
// ----------------------------------------------------------------------------
module cuc_time_packet_builder_unit
  import ctpb_pkg::*;
#(
  parameter int ET_BYTES = ET_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // request
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [ET_W-1:0]      s_tdata,   // [55:0] next_et
  input  logic                 s_tuser,   // [0] init_flag
  // packet bytes
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [BYTE_W-1:0]    m_tdata,   // [7:0] packet_byte
  output logic                 m_tlast,   // last_byte
  // configuration
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data
);

  ctpb_cmd_t  cmd;
  ctpb_stat_t stat;

  assign cfg_ready = 1'b1;

  ctpb_ctrl #(
    .ET_BYTES (ET_BYTES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ctpb_dp #(
    .ET_BYTES (ET_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cmd       (cmd),
    .stat      (stat)
  );

  // checks
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while a packet was in progress");

  a_no_emit_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !cmd.emit)
    else $error("byte emitted with no packet in progress");

  a_idle_after_crc: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && cmd.last |=> s_tready && m_tvalid && m_tlast)
    else $error("sequencer did not end the packet on the CRC byte");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    cmd.pos <= POS_W'(HDR_BYTES + ET_BYTES))
    else $error("byte position beyond the packet");

endmodule

// File: design/ctpb_ctrl.sv
// ----------------------------------------------------------------------------
// ctpb_ctrl - packet sequencer
// Takes a request when idle, then steps the byte position once per byte
// that the output register accepts, ending after the CRC byte.
// ----------------------------------------------------------------------------
module ctpb_ctrl
  import ctpb_pkg::*;
#(
  parameter int ET_BYTES = ET_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  ctpb_stat_t stat,
  output ctpb_cmd_t  cmd
);

  localparam int               PKT_BYTES = HDR_BYTES + ET_BYTES + 1;
  localparam logic [POS_W-1:0] LAST_POS  = POS_W'(PKT_BYTES - 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SEND = 1'b1;

  logic             state;
  logic             state_next;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic             accept;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid & s_tready;

  // commands
  assign cmd.load = accept;
  assign cmd.emit = (state == S_SEND) & stat.out_free;
  assign cmd.pos  = pos;
  assign cmd.last = (pos == LAST_POS);

  // next state
  always_comb begin
    state_next = state;
    pos_next   = pos;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_SEND;
          pos_next   = '0;
        end
      end
      S_SEND: begin
        if (cmd.emit) begin
          if (cmd.last) begin
            state_next = S_IDLE;
            pos_next   = '0;
          end else begin
            pos_next = pos + POS_W'(1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
        pos_next   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pos   <= '0;
    end else begin
      state <= state_next;
      pos   <= pos_next;
    end
  end

endmodule

// File: design/ctpb_dp.sv
// ----------------------------------------------------------------------------
// ctpb_dp - packet datapath
// Configuration registers, captured request, byte selection, running
// CRC-8 and the output register of the master side.
// ----------------------------------------------------------------------------
module ctpb_dp
  import ctpb_pkg::*;
#(
  parameter int ET_BYTES = ET_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_wr,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  // request
  input  logic [ET_W-1:0]      s_tdata,
  input  logic                 s_tuser,
  // result
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [BYTE_W-1:0]    m_tdata,
  output logic                 m_tlast,
  // control
  input  ctpb_cmd_t            cmd,
  output ctpb_stat_t           stat
);

  // unsent top bytes are shifted out of the way at capture
  localparam int ET_SKIP = BYTE_W * (ET_MAX_BYTES - ET_BYTES);

  logic [BYTE_W-1:0] dest_address;
  logic [BYTE_W-1:0] protocol_id;
  logic [TCID_W-1:0] time_code_id;
  logic [ET_W-1:0]   et_sh;
  logic              init_flag;
  logic [BYTE_W-1:0] running_crc;
  logic [BYTE_W-1:0] byte_sel;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dest_address <= RST_DEST;
      protocol_id  <= RST_PROTO;
      time_code_id <= RST_TCID;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_DEST:  dest_address <= cfg_data;
        REG_PROTO: protocol_id  <= cfg_data;
        REG_TCID:  time_code_id <= cfg_data[TCID_W-1:0];
        default: ;
      endcase
    end
  end

  // byte for the current position
  always_comb begin
    if (cmd.last) begin
      byte_sel = running_crc;
    end else if (cmd.pos == POS_DEST) begin
      byte_sel = dest_address;
    end else if (cmd.pos == POS_PROTO) begin
      byte_sel = protocol_id;
    end else if (cmd.pos == POS_PFIELD) begin
      byte_sel = {1'b1, time_code_id, 4'hF};
    end else if (cmd.pos == POS_PEXT) begin
      byte_sel = {init_flag, 7'd0};
    end else begin
      byte_sel = et_sh[ET_W-1 -: BYTE_W];
    end
  end

  // request capture; time bytes leave from the top of the shifter
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      et_sh     <= s_tdata << ET_SKIP;
      init_flag <= s_tuser;
    end else if (cmd.emit && (cmd.pos >= POS_W'(HDR_BYTES))) begin
      et_sh <= et_sh << BYTE_W;
    end
  end

  // running CRC over every byte before the CRC byte
  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= '0;
    end else if (cmd.load) begin
      running_crc <= '0;
    end else if (cmd.emit && !cmd.last) begin
      running_crc <= crc8_entry(running_crc ^ byte_sel);
    end
  end

  // output register
  assign stat.out_free = !m_tvalid | m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= byte_sel;
      m_tlast <= cmd.last;
    end
  end

endmodule

// File: bench/tb_cuc_time_packet_builder_unit.sv
// ----------------------------------------------------------------------------
// tb_cuc_time_packet_builder_unit - self-checking bench of the time packet builder
// Sends time requests, predicts the twelve packet bytes of each (header,
// time bytes, RMAP CRC-8) and compares every output beat in order.
// Covers register defaults, every register at its extremes, masking of wide
// register data, writes to the unused index, random traffic with random
// gaps on both sides and a long output stall that backs up the input.
// ----------------------------------------------------------------------------
module tb_cuc_time_packet_builder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import ctpb_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int REQ_PER_PHASE = 25;
  localparam int DRAIN_LIMIT   = 20000;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } pkt_byte_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [ET_W-1:0]      s_tdata;   // [55:0] next_et
  logic                 s_tuser;   // [0] init_flag
  logic                 m_tvalid;
  logic                 m_tready;
  logic [BYTE_W-1:0]    m_tdata;   // [7:0] packet_byte
  logic                 m_tlast;   // last_byte
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTE_W-1:0]    cfg_data;

  // bench copy of the registers
  logic [BYTE_W-1:0] pred_dest  = RST_DEST;
  logic [BYTE_W-1:0] pred_proto = RST_PROTO;
  logic [TCID_W-1:0] pred_tcid  = RST_TCID;

  pkt_byte_t exp_bytes[$];
  int        mismatch_count = 0;
  bit        tx_gaps_on = 1'b0;
  bit        rx_gaps_on = 1'b0;
  int        rx_hold_left = 0;

  cuc_time_packet_builder_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------- helpers

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [ET_W-1:0] random_et();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return r[ET_W-1:0];
    endcase
  endfunction

  // reflected CRC-8 (x^8+x^2+x+1), fed one data bit at a time, lsb first
  function automatic logic [BYTE_W-1:0] crc8_rmap_next(input logic [BYTE_W-1:0] crc,
                                                        input logic [BYTE_W-1:0] din);
    logic [BYTE_W-1:0] c;
    logic              fb;
    c = crc;
    for (int i = 0; i < BYTE_W; i++) begin
      fb = c[0] ^ din[i];
      c  = c >> 1;
      if (fb) c = c ^ CRC_POLY_REFL;
    end
    return c;
  endfunction

  // expected bytes of one time packet under the current registers
  task automatic predict_time_packet(input logic [ET_W-1:0] et, input logic init);
    logic [BYTE_W-1:0] crc;
    logic [BYTE_W-1:0] b;
    crc = '0;
    for (int k = 0; k < HDR_BYTES + ET_BYTES_DEF; k++) begin
      case (k)
        POS_DEST:   b = pred_dest;
        POS_PROTO:  b = pred_proto;
        POS_PFIELD: b = {1'b1, pred_tcid, 4'hF};
        POS_PEXT:   b = {init, 7'b0};
        default:    b = et[BYTE_W*(ET_BYTES_DEF-1-(k-HDR_BYTES)) +: BYTE_W];
      endcase
      exp_bytes.push_back('{data: b, last: 1'b0});
      crc = crc8_rmap_next(crc, b);
    end
    exp_bytes.push_back('{data: crc, last: 1'b1});
  endtask

  task automatic report_mismatch(input string what, input logic [BYTE_W-1:0] got,
                                 input logic [BYTE_W-1:0] want);
    $display("%0t ns: %s: got %02h, want %02h", $time, what, got, want);
    mismatch_count++;
  endtask

  // one request beat, then an optional gap; starts and ends on a falling edge
  task automatic send_request(input logic [ET_W-1:0] et, input logic init);
    int gap;
    s_tvalid = 1'b1;
    s_tdata  = et;
    s_tuser  = init;
    do @(posedge clk); while (!s_tready);
    predict_time_packet(et, init);
    @(negedge clk);
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    s_tvalid  = 1'b0;
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_DEST:  pred_dest  = val;
      REG_PROTO: pred_proto = val;
      REG_TCID:  pred_tcid  = val[TCID_W-1:0];
      default:   ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // all bytes out, then a wait for the sequencer to return to rest
  task automatic wait_idle();
    s_tvalid = 1'b0;
    while (exp_bytes.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // ---------------------------------------------------------------- receiver

  // output ready: long holds on request, random stalls when enabled
  initial begin : rx_ready_gen
    int stall_left;
    stall_left = 0;
    m_tready   = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_left > 0) begin
        m_tready = 1'b0;
        rx_hold_left--;
      end else if (stall_left > 0) begin
        m_tready = 1'b0;
        stall_left--;
      end else if (rx_gaps_on && $urandom_range(0, 3) == 0) begin
        m_tready   = 1'b0;
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 30)
                                                 : $urandom_range(0, 2);
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  // compare each output beat with the oldest expected byte
  always @(posedge clk) begin : byte_check
    pkt_byte_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (exp_bytes.size() == 0) begin
        report_mismatch("packet byte with none expected", m_tdata, '0);
      end else begin
        want = exp_bytes.pop_front();
        if (m_tdata !== want.data) report_mismatch("packet byte", m_tdata, want.data);
        if (m_tlast !== want.last) begin
          report_mismatch("last flag", BYTE_W'(m_tlast), BYTE_W'(want.last));
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // register defaults straight after reset
  task automatic test_reset_defaults();
    send_request('0, 1'b0);
    send_request('1, 1'b1);
    send_request(56'h01_2345_6789_ABCD, 1'b1);
    wait_idle();
  endtask

  // every register at both ends, wide data masked, unused index ignored
  task automatic test_register_extremes();
    write_reg(REG_DEST, 8'h00);
    write_reg(REG_PROTO, 8'hFF);
    write_reg(REG_TCID, 8'h07);
    send_request(56'hAA_AAAA_AAAA_AAAA, 1'b0);
    send_request(56'h55_5555_5555_5555, 1'b1);
    wait_idle();
    write_reg(REG_DEST, 8'hFF);
    write_reg(REG_PROTO, 8'h00);
    write_reg(REG_TCID, 8'h00);
    send_request('1, 1'b0);
    send_request('0, 1'b1);
    wait_idle();
    // upper bits of the time code id are dropped
    write_reg(REG_TCID, 8'hFA);
    // no register behind this index
    write_reg(REG_UNUSED, 8'h3C);
    send_request(56'h80_0000_0000_0001, 1'b0);
    send_request(56'h7F_FFFF_FFFF_FFFE, 1'b1);
    wait_idle();
    write_reg(REG_TCID, 8'h02);
    write_reg(REG_DEST, 8'h5A);
    write_reg(REG_PROTO, 8'hA5);
    send_request(56'hFF_0000_0000_00FF, 1'b0);
    send_request(56'h00_FF00_FF00_FF00, 1'b1);
    wait_idle();
  endtask

  // random requests in phases, new registers and idling mix per phase
  task automatic test_random_traffic();
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_DEST, BYTE_W'($urandom_range(0, 255)));
      write_reg(REG_PROTO, BYTE_W'($urandom_range(0, 255)));
      write_reg(REG_TCID, BYTE_W'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) == 1) write_reg(REG_UNUSED, BYTE_W'($urandom_range(0, 255)));
      tx_gaps_on = ph[0];
      rx_gaps_on = ph[1];
      for (int n = 0; n < REQ_PER_PHASE; n++) begin
        send_request(random_et(), 1'($urandom_range(0, 1)));
      end
      wait_idle();
    end
  endtask

  // long output hold while requests keep coming, input has to stall
  task automatic test_output_backpressure();
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    @(posedge clk);
    rx_hold_left = 80;
    @(negedge clk);
    for (int n = 0; n < 6; n++) begin
      send_request(random_et(), 1'($urandom_range(0, 1)));
    end
    rx_gaps_on = 1'b1;
    wait_idle();
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin : run_tests
    int cyc;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_DEST;
    cfg_data  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    repeat (2) @(negedge clk);

    test_reset_defaults();
    test_register_extremes();
    test_random_traffic();
    test_output_backpressure();

    // drain with a bound, anything still waiting is a failure
    cyc = 0;
    while (exp_bytes.size() != 0 && cyc < DRAIN_LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    if (exp_bytes.size() != 0) begin
      report_mismatch("bytes never sent", BYTE_W'(exp_bytes.size()), '0);
    end
    repeat (20) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: cuc_time_packet_builder_unit.f
design/ctpb_pkg.sv
design/ctpb_ctrl.sv
design/ctpb_dp.sv
design/cuc_time_packet_builder_unit.sv
bench/tb_cuc_time_packet_builder_unit.sv
